// ===== hdl/lcs_pkg.sv =====
package lcs_pkg;

    // field and register widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int COEFF_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int EMIT_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // table sizes
    localparam int BYTE_VALUES = 256;
    localparam int CBD_VALUES  = 9;
    localparam int CBD_IDX_W   = 4;
    localparam int CBD_OFFSET  = 4;

    // defaults
    localparam int unsigned          DEF_MODULUS_Q   = 3329;
    localparam logic [COUNT_W-1:0]   DEF_COEFF_COUNT = 13'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT = 1'b1;

    // sample modes
    localparam logic MODE_BINOMIAL = 1'b0;
    localparam logic MODE_UNIFORM  = 1'b1;

    typedef logic [WORD_W-1:0] t_mod;
    typedef t_mod t_mod_tab [BYTE_VALUES];
    typedef t_mod t_cbd_tab [CBD_VALUES];

endpackage

// ===== hdl/lattice_coeff_sampler_top.sv =====
// channel   | handshake           | payload
// ----------+---------------------+------------------------------
// input     | i_valid / o_ready   | i_rand_byte (8)
// output    | o_valid / i_ready   | o_coeff (12), o_last_coeff (1)
// config    | i_cfg_we            | i_cfg_idx (1), i_cfg_data (13)
//
// one byte is taken every cycle while o_ready is high; a result appears in the cycle after the byte
// that causes it, in the single result register
// binomial mode gives a coefficient per byte, uniform mode one per accepted
// byte pair (none for a first byte or a rejected word)
// reset (synchronous, active low) restores mode uniform, count 256, clears
// the held half word and the coefficient counter
// o_ready drops only while a result waits and i_ready is low
module lattice_coeff_sampler_top #(
    parameter int unsigned MODULUS_Q = lcs_pkg::DEF_MODULUS_Q
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lcs_pkg::BYTE_W-1:0]      i_rand_byte,

    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lcs_pkg::COEFF_W-1:0]     o_coeff,
    output logic                            o_last_coeff,

    input  logic                            i_cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import lcs_pkg::*;

    // largest multiple of q that fits in 16 bits
    localparam int unsigned LIMIT = 65535 - (65535 % MODULUS_Q);

    // (hi * 256) mod q, looked up when the first byte of a pair arrives
    function automatic t_mod_tab build_hi_tab();
        t_mod_tab tab;
        for (int i = 0; i < BYTE_VALUES; i++) begin
            tab[i] = t_mod'((i * 256) % MODULUS_Q);
        end
        return tab;
    endfunction

    // lo mod q
    function automatic t_mod_tab build_lo_tab();
        t_mod_tab tab;
        for (int i = 0; i < BYTE_VALUES; i++) begin
            tab[i] = t_mod'(i % MODULUS_Q);
        end
        return tab;
    endfunction

    // centered difference -4..4 reduced into 0..q-1
    function automatic t_cbd_tab build_cbd_tab();
        t_cbd_tab tab;
        int       m;
        for (int d = -CBD_OFFSET; d <= CBD_OFFSET; d++) begin
            if (d >= 0) begin
                tab[d + CBD_OFFSET] = t_mod'(d % MODULUS_Q);
            end else begin
                m = (-d) % MODULUS_Q;
                tab[d + CBD_OFFSET] = (m == 0) ? '0 : t_mod'(MODULUS_Q - m);
            end
        end
        return tab;
    endfunction

    function automatic logic [2:0] pop4(input logic [3:0] n);
        return {2'b00, n[0]} + {2'b00, n[1]} + {2'b00, n[2]} + {2'b00, n[3]};
    endfunction

    localparam t_mod_tab HI_TAB  = build_hi_tab();
    localparam t_mod_tab LO_TAB  = build_lo_tab();
    localparam t_cbd_tab CBD_TAB = build_cbd_tab();

    // configuration
    logic                   r_sample_mode;
    logic [COUNT_W-1:0]     r_coeff_count;

    // pairing state
    logic                   r_pending;
    logic [BYTE_W-1:0]      r_high_byte;
    t_mod                   r_high_mod;
    logic                   n_pending;

    // polynomial position
    logic [EMIT_W-1:0]      r_emit_cnt;
    logic [EMIT_W-1:0]      n_emit_cnt;

    // result register
    logic                   r_out_valid;
    logic [COEFF_W-1:0]     r_coeff;
    logic                   r_last;

    logic                   take;
    logic                   emit;
    t_mod                   value;
    logic                   last;
    logic [COUNT_W-1:0]     next_cnt;
    logic [CBD_IDX_W-1:0]   cbd_idx;
    logic [WORD_W-1:0]      word;
    logic [WORD_W:0]        mod_sum;
    t_mod                   uni_mod;

    assign o_ready      = !r_out_valid || i_ready;
    assign o_valid      = r_out_valid;
    assign o_coeff      = r_coeff;
    assign o_last_coeff = r_last;

    assign take = i_valid && o_ready;

    // binomial: popcount(high nibble) - popcount(low nibble), offset by four
    assign cbd_idx = CBD_IDX_W'(CBD_OFFSET) + {1'b0, pop4(i_rand_byte[7:4])}
                     - {1'b0, pop4(i_rand_byte[3:0])};

    // uniform: held (hi*256 mod q) plus (lo mod q), one conditional subtract
    assign word    = {r_high_byte, i_rand_byte};
    assign mod_sum = {1'b0, r_high_mod} + {1'b0, LO_TAB[i_rand_byte]};
    assign uni_mod = (mod_sum >= (WORD_W+1)'(MODULUS_Q))
                     ? t_mod'(mod_sum - (WORD_W+1)'(MODULUS_Q))
                     : t_mod'(mod_sum);

    always_comb begin
        emit      = 1'b0;
        value     = '0;
        n_pending = r_pending;
        if (r_sample_mode == MODE_BINOMIAL) begin
            emit  = 1'b1;
            value = CBD_TAB[cbd_idx];
        end else if (!r_pending) begin
            n_pending = 1'b1;
        end else begin
            n_pending = 1'b0;
            // reject words above the largest multiple of q
            emit      = (word <= WORD_W'(LIMIT));
            value     = uni_mod;
        end
    end

    // last flag when the count is reached or the counter tops out
    assign next_cnt   = {1'b0, r_emit_cnt} + COUNT_W'(1);
    assign last       = (next_cnt >= r_coeff_count) || (&r_emit_cnt);
    assign n_emit_cnt = last ? '0 : next_cnt[EMIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_mode <= MODE_UNIFORM;
            r_coeff_count <= DEF_COEFF_COUNT;
            r_pending     <= 1'b0;
            r_high_byte   <= '0;
            r_emit_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SAMPLE_MODE: begin
                        r_sample_mode <= i_cfg_data[0];
                        r_pending     <= 1'b0;
                    end
                    REG_COEFF_COUNT: begin
                        r_coeff_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else if (take) begin
                r_pending <= n_pending;
            end

            if (take && r_sample_mode == MODE_UNIFORM && !r_pending) begin
                r_high_byte <= i_rand_byte;
            end

            if (take && emit) begin
                r_emit_cnt <= n_emit_cnt;
            end

            if (take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take && r_sample_mode == MODE_UNIFORM && !r_pending) begin
            r_high_mod <= HI_TAB[i_rand_byte];
        end
        if (take && emit) begin
            r_coeff <= value[COEFF_W-1:0];
            r_last  <= last;
        end
    end

endmodule
